>>> hw/rtl/min_squares_sum_count_top_macros.svh
// Assertion macros for the minimum square count block.
// Used by min_squares_sum_count_top; depends on nothing else.
`ifndef MIN_SQUARES_SUM_COUNT_TOP_MACROS_SVH
`define MIN_SQUARES_SUM_COUNT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define MSSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mssc assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define MSSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mssc assertion failed");
`else
`define MSSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/mssc_pkg.sv
// Shared constants and types for the minimum square count block.
// Depends on nothing; imported by mssc_seq and the top module.
package mssc_pkg;

    localparam int MAX_TARGET = 4095;
    localparam int TARGET_W   = 12;
    localparam int COUNT_W    = 3;
    localparam int DEPTH      = MAX_TARGET + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    // square and odd-step registers need one bit above the address
    localparam int SQ_W       = ADDR_W + 1;
    localparam int CMP_W      = (TARGET_W > ADDR_W) ? TARGET_W : ADDR_W;

    localparam logic [COUNT_W-1:0] COUNT_NONE = COUNT_W'(7);

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [COUNT_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        logic               busy;
        logic               res_load;
        logic [COUNT_W-1:0] res_count;
    } t_seq_stat;

endpackage

>>> hw/rtl/mssc_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// Generic storage for the best-count table; no package dependency.
module mssc_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 3,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mssc_seq.sv
// Table fill sequencer (uses mssc_pkg): walks v and the squares below it,
// issues one table read a cycle while a square fits; keeps a running min.
module mssc_seq
    import mssc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ADDR_W-1:0]  i_target,
    input  logic               i_out_free,
    input  logic [COUNT_W-1:0] i_rd_data,
    output t_ram_req           o_ram,
    output t_seq_stat          o_stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEED0 = 3'd1;
    localparam logic [2:0] ST_SEED1 = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_target, n_target;
    logic [ADDR_W-1:0]  r_v, n_v;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [SQ_W-1:0]    r_odd, n_odd;
    logic [COUNT_W-1:0] r_best, n_best;
    logic               r_rd_vld, n_rd_vld;
    logic [COUNT_W-1:0] r_res, n_res;

    logic [SQ_W-1:0]    w_v_ext;
    logic               w_sq_fits;
    logic [COUNT_W:0]   w_cand;
    logic [COUNT_W-1:0] w_best_now;

    // fold the returning table entry into the running minimum
    assign w_cand  = {1'b0, i_rd_data} + (COUNT_W+1)'(1);
    always_comb begin
        w_best_now = r_best;
        if (r_rd_vld && (w_cand < {1'b0, r_best})) begin
            w_best_now = w_cand[COUNT_W-1:0];
        end
    end

    assign w_v_ext   = {1'b0, r_v};
    assign w_sq_fits = (r_sq <= w_v_ext);

    // next-state and datapath control
    always_comb begin
        n_state  = r_state;
        n_target = r_target;
        n_v      = r_v;
        n_sq     = r_sq;
        n_odd    = r_odd;
        n_best   = w_best_now;
        n_rd_vld = 1'b0;
        n_res    = r_res;
        o_ram    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_target = i_target;
                    n_state  = ST_SEED0;
                end
            end
            ST_SEED0: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = '0;
                o_ram.wdata = '0;
                if (r_target == '0) begin
                    n_res   = '0;
                    n_state = ST_POST;
                end else begin
                    n_state = ST_SEED1;
                end
            end
            ST_SEED1: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = ADDR_W'(1);
                o_ram.wdata = COUNT_W'(1);
                if (r_target == ADDR_W'(1)) begin
                    n_res   = COUNT_W'(1);
                    n_state = ST_POST;
                end else begin
                    n_v     = ADDR_W'(2);
                    n_sq    = SQ_W'(1);
                    n_odd   = SQ_W'(3);
                    n_best  = COUNT_NONE;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_sq_fits) begin
                    // issue read of entry v - s, step to next square
                    o_ram.re    = 1'b1;
                    o_ram.raddr = ADDR_W'(w_v_ext - r_sq);
                    n_rd_vld    = 1'b1;
                    n_sq        = r_sq + r_odd;
                    n_odd       = r_odd + SQ_W'(2);
                end else begin
                    // all squares done: store entry v, advance or finish
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_v;
                    o_ram.wdata = w_best_now;
                    if (r_v == r_target) begin
                        n_res   = w_best_now;
                        n_state = ST_POST;
                    end else begin
                        n_v    = r_v + ADDR_W'(1);
                        n_sq   = SQ_W'(1);
                        n_odd  = SQ_W'(3);
                        n_best = COUNT_NONE;
                    end
                end
            end
            ST_POST: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_v      <= n_v;
        r_sq     <= n_sq;
        r_odd    <= n_odd;
        r_best   <= n_best;
        r_res    <= n_res;
    end

    assign o_stat.busy      = (r_state != ST_IDLE);
    assign o_stat.res_load  = (r_state == ST_POST) && i_out_free;
    assign o_stat.res_count = r_res;

endmodule

>>> hw/rtl/min_squares_sum_count_top.sv
// Throughput: one request at a time; the input stays stalled until the result is loaded.
// Reset: synchronous active-low i_rst_n clears the sequencer and output valid;
// the table needs no clearing, every entry is written before it is read.
`include "min_squares_sum_count_top_macros.svh"
module min_squares_sum_count_top
    import mssc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [TARGET_W-1:0] i_target,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COUNT_W-1:0] o_square_count
);

    t_ram_req           w_ram;
    t_seq_stat          w_stat;
    logic [COUNT_W-1:0] w_rd_data;
    logic [ADDR_W-1:0]  w_target_sat;
    logic [CMP_W-1:0]   w_target_ext;
    logic               w_out_free;
    logic               w_start;

    logic               r_out_vld;
    logic [COUNT_W-1:0] r_count;

    // clamp the target to the table size
    assign w_target_ext = CMP_W'(i_target);
    assign w_target_sat = (w_target_ext > CMP_W'(MAX_TARGET)) ?
                          ADDR_W'(MAX_TARGET) : ADDR_W'(w_target_ext);

    assign o_in_stall = w_stat.busy;
    assign w_start    = i_in_valid && !w_stat.busy;
    assign w_out_free = !r_out_vld || !i_out_stall;

    mssc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_target  (w_target_sat),
        .i_out_free(w_out_free),
        .i_rd_data (w_rd_data),
        .o_ram     (w_ram),
        .o_stat    (w_stat)
    );

    mssc_ram #(
        .DEPTH (DEPTH),
        .DATA_W(COUNT_W),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram.we),
        .i_waddr(w_ram.waddr),
        .i_wdata(w_ram.wdata),
        .i_re   (w_ram.re),
        .i_raddr(w_ram.raddr),
        .o_rdata(w_rd_data)
    );

    // hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_stat.res_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_load) begin
            r_count <= w_stat.res_count;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_square_count = r_count;

    // an accepted request keeps the input stalled until it is answered
    `MSSC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a new result never overwrites one still waiting
    `MSSC_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_stat.res_load, w_out_free)
    // no answer exceeds four squares
    `MSSC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_out_valid, o_square_count <= COUNT_W'(4))
    // reads and writes of the table never collide in one cycle
    `MSSC_ASSERT_IMP(a_one_access, i_clk, i_rst_n, w_ram.we, !w_ram.re)

endmodule
